// ===== src/amhw_pkg.sv =====
// ----------------------------------------------------------------------------
// amhw_pkg
// Shared types, constants and mask helpers for the alarm mask and heartbeat
// watchdog block.
// ----------------------------------------------------------------------------
package amhw_pkg;

  localparam int ALARM_BITS = 32;
  localparam int MASK_W     = 32;
  localparam int TIME_W     = 32;
  localparam int POS_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [MASK_W-1:0] ALARM_MASK = (ALARM_BITS >= MASK_W) ? {MASK_W{1'b1}} :
      MASK_W'((64'd1 << ALARM_BITS) - 64'd1);
  localparam logic [MASK_W-1:0] SENSOR_RANGE    = 32'hFFF0_0000;
  localparam logic [TIME_W-1:0] TONE_DEFAULT_MS = 32'd5000;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_RAISE  = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_CLRALL = 3'd3;
  localparam logic [2:0] OP_REMOTE = 3'd4;
  localparam logic [2:0] OP_ACK    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_HB_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HB_TIMEOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_REPEAT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_EN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_BIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CONN_BIT    = 3'd5;

  typedef struct packed {
    logic [2:0]        operation;
    logic [TIME_W-1:0] now_ms;
    logic [MASK_W-1:0] alarm_bits;
    logic [MASK_W-1:0] remote_bits;
    logic              tone_busy;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] active_mask;
    logic [MASK_W-1:0] local_mask;
    logic [MASK_W-1:0] remote_mask;
    logic              send_heartbeat;
    logic              play_tone;
    logic              alarm_led;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] heartbeat_interval_ms;
    logic [TIME_W-1:0] heartbeat_timeout_ms;
    logic [TIME_W-1:0] tone_repeat_ms;
    logic              tone_enable;
    logic [POS_W-1:0]  sensor_failure_bit;
    logic [POS_W-1:0]  connection_lost_bit;
  } cfg_t;

  function automatic logic [MASK_W-1:0] bit_of(input logic [POS_W-1:0] pos);
    logic [MASK_W-1:0] b;
    b = MASK_W'(1) << pos;
    return b & ALARM_MASK;
  endfunction

  function automatic logic [MASK_W-1:0] raise_f(input logic [MASK_W-1:0] lm,
                                                input logic [MASK_W-1:0] bits,
                                                input logic [POS_W-1:0]  sfb);
    logic [MASK_W-1:0] r;
    r = lm;
    if (bits != '0) begin
      r = (lm | bits) & ALARM_MASK;
      if ((bits & SENSOR_RANGE) != '0) r = r | bit_of(sfb);
    end
    return r;
  endfunction

  function automatic logic [MASK_W-1:0] clear_f(input logic [MASK_W-1:0] lm,
                                                input logic [MASK_W-1:0] bits,
                                                input logic [POS_W-1:0]  sfb);
    logic [MASK_W-1:0] r;
    logic [MASK_W-1:0] sf;
    r  = lm;
    sf = bit_of(sfb);
    if (bits != '0) begin
      r = lm & ~bits;
      if ((bits & SENSOR_RANGE) != '0 && (r & SENSOR_RANGE & ~sf) == '0) r = r & ~sf;
    end
    return r;
  endfunction

endpackage

// ===== src/amhw_cfg.sv =====
// ----------------------------------------------------------------------------
// amhw_cfg
// Configuration register file, write only, indexed by register number.
// ----------------------------------------------------------------------------
module amhw_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [amhw_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [amhw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output amhw_pkg::cfg_t                 cfg
);
  import amhw_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_HB_INTERVAL: cfg_nxt.heartbeat_interval_ms = cfg_wdata[TIME_W-1:0];
        CFG_HB_TIMEOUT:  cfg_nxt.heartbeat_timeout_ms  = cfg_wdata[TIME_W-1:0];
        CFG_TONE_REPEAT: cfg_nxt.tone_repeat_ms        = cfg_wdata[TIME_W-1:0];
        CFG_TONE_EN:     cfg_nxt.tone_enable           = cfg_wdata[0];
        CFG_SENSOR_BIT:  cfg_nxt.sensor_failure_bit    = cfg_wdata[POS_W-1:0];
        CFG_CONN_BIT:    cfg_nxt.connection_lost_bit   = cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{heartbeat_interval_ms: '0, heartbeat_timeout_ms: '0,
                 tone_repeat_ms: '0, tone_enable: 1'b0,
                 sensor_failure_bit: POS_W'(0), connection_lost_bit: POS_W'(1)};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/amhw_engine.sv =====
// ----------------------------------------------------------------------------
// amhw_engine
// Alarm state, heartbeat watchdog and tone retrigger: one request per step.
// ----------------------------------------------------------------------------
module amhw_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  amhw_pkg::in_item_t  item,
  input  amhw_pkg::cfg_t      cfg,
  output amhw_pkg::out_item_t res
);
  import amhw_pkg::*;

  logic [MASK_W-1:0] local_r, local_nxt;
  logic [MASK_W-1:0] remote_r, remote_nxt;
  logic [MASK_W-1:0] prev_r, prev_nxt;
  logic [TIME_W-1:0] tone_t_r, tone_t_nxt;
  logic [TIME_W-1:0] sent_t_r, sent_t_nxt;
  logic [TIME_W-1:0] ack_t_r, ack_t_nxt;

  logic [MASK_W-1:0] abits, rbits, clb, lm, rm, cur;
  logic [TIME_W-1:0] now, rep, sent_t, tone_t;
  logic              hb, tone, sent, connected;

  always_comb begin
    now    = item.now_ms;
    abits  = item.alarm_bits & ALARM_MASK;
    rbits  = item.remote_bits & ALARM_MASK;
    clb    = bit_of(cfg.connection_lost_bit);
    rep    = (cfg.tone_repeat_ms != '0) ? cfg.tone_repeat_ms : TONE_DEFAULT_MS;
    lm     = local_r;
    rm     = remote_r;
    sent_t = sent_t_r;
    tone_t = tone_t_r;
    hb     = 1'b0;
    tone   = 1'b0;
    sent   = (now - sent_t_r) >= cfg.heartbeat_interval_ms;
    connected = (ack_t_r != '0) && ((now - ack_t_r) < cfg.heartbeat_timeout_ms);
    cur    = '0;
    prev_nxt  = prev_r;
    ack_t_nxt = ack_t_r;

    unique case (item.operation)
      OP_TICK: begin
        if (cfg.heartbeat_interval_ms != '0) begin
          if (sent) begin
            hb     = 1'b1;
            sent_t = now;
          end
          if (sent_t != '0 || now >= cfg.heartbeat_timeout_ms) begin
            if (connected) begin
              lm = clear_f(lm, clb, cfg.sensor_failure_bit);
            end else begin
              lm = raise_f(lm, clb, cfg.sensor_failure_bit);
              rm = '0;
            end
          end
        end
        if (cfg.tone_enable) begin
          cur = lm | rm;
          if (cur != '0) begin
            if ((cur & ~prev_r) != '0) begin
              tone   = 1'b1;
              tone_t = now;
            end else if (tone_t_r != '0 && !item.tone_busy && (now - tone_t_r) >= rep) begin
              tone   = 1'b1;
              tone_t = now;
            end
          end else begin
            tone_t = '0;
          end
          prev_nxt = cur;
        end
      end
      OP_RAISE:  lm = raise_f(local_r, abits, cfg.sensor_failure_bit);
      OP_CLEAR:  lm = clear_f(local_r, abits, cfg.sensor_failure_bit);
      OP_CLRALL: begin
        lm = '0;
        rm = '0;
      end
      OP_REMOTE: rm = rbits;
      OP_ACK: begin
        ack_t_nxt = now;
        lm        = clear_f(local_r, clb, cfg.sensor_failure_bit);
      end
      default: ;
    endcase

    local_nxt  = lm;
    remote_nxt = rm;
    sent_t_nxt = sent_t;
    tone_t_nxt = tone_t;

    res.active_mask    = lm | rm;
    res.local_mask     = lm;
    res.remote_mask    = rm;
    res.send_heartbeat = hb;
    res.play_tone      = tone;
    res.alarm_led      = (lm | rm) != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_r  <= '0;
      remote_r <= '0;
      prev_r   <= '0;
      tone_t_r <= '0;
      sent_t_r <= '0;
      ack_t_r  <= '0;
    end else if (step) begin
      local_r  <= local_nxt;
      remote_r <= remote_nxt;
      prev_r   <= prev_nxt;
      tone_t_r <= tone_t_nxt;
      sent_t_r <= sent_t_nxt;
      ack_t_r  <= ack_t_nxt;
    end
  end

endmodule

// ===== src/alarm_mask_heartbeat_watchdog_top.sv =====
// ----------------------------------------------------------------------------
// alarm_mask_heartbeat_watchdog_top
// A request moves from the input register to the result register, which
// drives out_valid. Throughput: one request per cycle while out_ready is
// high. The result register frees the input side while a result waits.
// Reset (synchronous, active low) clears all masks and times to zero and
// returns the configuration to its defaults.
// ----------------------------------------------------------------------------
module alarm_mask_heartbeat_watchdog_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  amhw_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output amhw_pkg::out_item_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [amhw_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [amhw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import amhw_pkg::*;

  cfg_t      cfg;
  in_item_t  item_r;
  logic      item_vld_r;
  out_item_t res;
  out_item_t res_r;
  logic      res_vld_r;
  logic      advance;

  assign advance  = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !item_vld_r || advance;

  amhw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  amhw_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_ready) item_vld_r <= in_valid;
      if (advance) begin
        res_vld_r <= 1'b1;
      end else if (out_ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) item_r <= in_data;
    if (advance) res_r <= res;
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

endmodule

// ===== src/amhw_checker.sv =====
// ----------------------------------------------------------------------------
// amhw_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module amhw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input amhw_pkg::out_item_t out_data
);
  import amhw_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.active_mask == (out_data.local_mask | out_data.remote_mask))
    else $error("active mask is not local or remote");

  a_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.alarm_led == (out_data.active_mask != '0))
    else $error("alarm led disagrees with active mask");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind alarm_mask_heartbeat_watchdog_top amhw_checker u_amhw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
